@@ design/bpa_pkg.sv @@
`default_nettype none
package bpa_pkg;

  // Request codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  // Field widths fixed by the interface.
  localparam int ORD_W = 4;
  localparam int IDX_W = 10;
  localparam int TOT_W = 11;

endpackage
`default_nettype wire

@@ design/bpa_page_ram.sv @@
`default_nettype none
module bpa_page_ram #(
  parameter int AW = 10,
  parameter int DW = 27
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/buddy_page_allocator.sv @@
`default_nettype none
// Buddy allocator over PAGES pages with one free list per order 0..MAX_ORD.
// Issue a request by raising start while busy is low; exactly one result
// follows, shown for one cycle with done high, and it cannot be held off.
// After reset the block stays busy while a clearing pass
// zeroes every page record, free marks included.
// The per-page records (free mark, order, next and previous links) live in
// one memory with a single registered read port, so each update of a stored
// record reads it, then writes it back; the port sets the time an item takes.
// A request rejected for its order, range or alignment shows its result in
// the cycle after it is accepted, and a double free after the S_FTST check
// of its free mark. The longest allocate is a full scan and split chain; a
// free runs one buddy check and unlink per merge before its final push.
// Busy drops in the cycle after the result.
module buddy_page_allocator #(
  parameter int PAGES   = 1024,
  parameter int MAX_ORD = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      func,
  input  wire logic [bpa_pkg::ORD_W-1:0] order,
  input  wire logic [bpa_pkg::IDX_W-1:0] block_index,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [bpa_pkg::IDX_W-1:0]      result_index,
  output logic [bpa_pkg::TOT_W-1:0]      free_count
);
  import bpa_pkg::*;

  localparam int AW   = (PAGES > 2) ? $clog2(PAGES) : 1;
  localparam int LW   = $clog2(PAGES + 1);
  localparam int OW   = $clog2(MAX_ORD + 1);
  localparam int LEV  = MAX_ORD + 1;
  localparam int DW   = 1 + OW + 2 * LW;
  localparam int TW   = AW + 2;
  localparam logic [LW-1:0] NIL = LW'(PAGES);

  // Record fields: {free mark, order, next, prev}.
  typedef struct packed {
    logic          fm;
    logic [OW-1:0] ord;
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
  } rec_t;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHECK = 5'd1;
  localparam logic [4:0] S_SCAN  = 5'd2;
  localparam logic [4:0] S_UL_RD = 5'd3;
  localparam logic [4:0] S_UL_W  = 5'd4;
  localparam logic [4:0] S_UL_P  = 5'd5;
  localparam logic [4:0] S_UL_PW = 5'd6;
  localparam logic [4:0] S_UL_N  = 5'd7;
  localparam logic [4:0] S_UL_NW = 5'd8;
  localparam logic [4:0] S_AFTUL = 5'd9;
  localparam logic [4:0] S_PUSH  = 5'd10;
  localparam logic [4:0] S_PU_H  = 5'd11;
  localparam logic [4:0] S_PU_HW = 5'd12;
  localparam logic [4:0] S_AFTPU = 5'd13;
  localparam logic [4:0] S_MRG   = 5'd14;
  localparam logic [4:0] S_MRG_R = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;
  localparam logic [4:0] S_CLR   = 5'd17;
  localparam logic [4:0] S_FTST  = 5'd18;

  logic [4:0]          state;
  logic                fn;
  logic [OW-1:0]       req_ord;
  logic [OW-1:0]       cur;
  logic [LW-1:0]       blk;
  logic [LW-1:0]       bud;
  logic [LW-1:0]       ul_p, ul_n;
  logic [LW-1:0]       head [LEV];
  logic [LW-1:0]       cnt  [LEV];
  logic [TW-1:0]       total;
  logic [AW-1:0]       clr;
  logic [1:0]          st;
  logic [LW-1:0]       res;

  // Memory port.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  rec_t          wrec, rrec;
  logic [DW-1:0] rdata;

  bpa_page_ram #(.AW(AW), .DW(DW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wrec),
    .raddr(raddr), .rdata(rdata)
  );
  assign rrec = rec_t'(rdata);

  // Free-request range and alignment checks; the free mark is read later.
  logic [LW:0]   sz_in;
  logic          bad_free;
  logic [LW-1:0] idx_ext;
  always_comb begin
    idx_ext  = LW'(block_index);
    sz_in    = (LW+1)'(1) << order;
    bad_free = ((LW+1)'(idx_ext) + sz_in > (LW+1)'(PAGES)) ||
               ((idx_ext & LW'(sz_in - 1'b1)) != '0);
  end

  // Buddy of the block at the current order.
  logic [LW-1:0] bud_c;
  assign bud_c = blk ^ (LW'(1) << cur);

  always_comb begin
    we    = 1'b0;
    waddr = AW'(blk);
    wrec  = '0;
    raddr = AW'(blk);
    case (state)
      S_IDLE:  raddr = AW'(block_index);
      S_CLR: begin
        we    = 1'b1;
        waddr = clr;
      end
      S_UL_RD: raddr = AW'(bud);
      S_UL_P:  raddr = AW'(ul_p);
      S_UL_N:  raddr = AW'(ul_n);
      S_MRG:   raddr = AW'(bud_c);
      S_PU_H:  raddr = AW'(ul_n);
      S_UL_W: begin
        we    = 1'b1;
        waddr = AW'(bud);
        if (fn == FUNC_ALLOC) begin
          wrec = '{fm: 1'b0, ord: rrec.ord, nxt: rrec.nxt, prv: rrec.prv};
        end else begin
          wrec = '{fm: 1'b0, ord: cur, nxt: ul_n, prv: ul_p};
        end
      end
      S_PUSH: begin
        we    = 1'b1;
        waddr = AW'(blk);
        wrec  = '{fm: 1'b1, ord: cur, nxt: head[cur], prv: NIL};
        raddr = AW'(head[cur]);
      end
      S_UL_PW: begin
        we    = 1'b1;
        waddr = AW'(ul_p);
        wrec  = '{fm: rrec.fm, ord: rrec.ord, nxt: ul_n, prv: rrec.prv};
      end
      S_UL_NW: begin
        we    = 1'b1;
        waddr = AW'(ul_n);
        wrec  = '{fm: rrec.fm, ord: rrec.ord, nxt: rrec.nxt, prv: ul_p};
      end
      S_PU_HW: begin
        we    = 1'b1;
        waddr = AW'(ul_n);
        wrec  = '{fm: rrec.fm, ord: rrec.ord, nxt: rrec.nxt, prv: blk};
      end
      default: ;
    endcase
  end

  assign busy         = (state != S_IDLE);
  assign done         = (state == S_DONE);
  assign status       = st;
  assign result_index = IDX_W'(res);
  assign free_count   = TOT_W'(total);

  // Sequencer: scan, unlink, split or merge, push.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr   <= '0;
      total <= '0;
      for (int i = 0; i < LEV; i++) begin
        head[i] <= NIL;
        cnt[i]  <= '0;
      end
    end else begin
      case (state)
        // Zero every page record once after reset.
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == AW'(PAGES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            fn      <= func;
            req_ord <= OW'(order);
            cur     <= OW'(order);
            blk     <= idx_ext;
            st      <= ST_OK;
            res     <= '0;
            if (order > ORD_W'(MAX_ORD)) begin
              st    <= ST_BAD;
              state <= S_DONE;
            end else if (func == FUNC_ALLOC) begin
              state <= S_SCAN;
            end else if (bad_free) begin
              st    <= ST_BAD;
              state <= S_DONE;
            end else begin
              state <= S_FTST;
            end
          end
        end
        // Free: a base that already heads a free block is a double free.
        S_FTST: begin
          if (rrec.fm) begin
            st    <= ST_BAD;
            state <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_SCAN: begin
          if (cnt[cur] != '0 && head[cur] != NIL) begin
            bud   <= head[cur];
            blk   <= head[cur];
            state <= S_UL_RD;
          end else if (cur == OW'(MAX_ORD)) begin
            st    <= ST_NOSPACE;
            state <= S_DONE;
          end else begin
            cur <= cur + 1'b1;
          end
        end
        // Free: test the buddy at the current order.
        S_CHECK: begin
          if (cur == OW'(MAX_ORD) || bud_c >= NIL) begin
            state <= S_PUSH;
          end else begin
            bud   <= bud_c;
            state <= S_MRG;
          end
        end
        S_MRG:   state <= S_MRG_R;
        S_MRG_R: begin
          if (!rrec.fm || rrec.ord != cur) begin
            state <= S_PUSH;
          end else begin
            ul_p  <= rrec.prv;
            ul_n  <= rrec.nxt;
            state <= S_UL_W;
          end
        end
        S_UL_RD: state <= S_UL_W;
        S_UL_W: begin
          if (state == S_UL_W && fn == FUNC_ALLOC) begin
            ul_p <= rrec.prv;
            ul_n <= rrec.nxt;
          end
          if (cnt[cur] != '0) cnt[cur] <= cnt[cur] - 1'b1;
          state <= S_UL_P;
        end
        S_UL_P: begin
          if (ul_p < NIL) begin
            state <= S_UL_PW;
          end else begin
            head[cur] <= ul_n;
            state     <= S_UL_N;
          end
        end
        S_UL_PW: state <= S_UL_N;
        S_UL_N:  state <= (ul_n < NIL) ? S_UL_NW : S_AFTUL;
        S_UL_NW: state <= S_AFTUL;
        S_AFTUL: begin
          if (fn == FUNC_FREE) begin
            if (bud < blk) blk <= bud;
            cur   <= cur + 1'b1;
            state <= S_CHECK;
          end else if (cur > req_ord) begin
            cur   <= cur - 1'b1;
            bud   <= blk;
            blk   <= blk + (LW'(1) << (cur - 1'b1));
            state <= S_PUSH;
          end else begin
            total <= total - (TW'(1) << req_ord);
            res   <= blk;
            state <= S_DONE;
          end
        end
        // The old head is kept so its back link can be patched.
        S_PUSH: begin
          ul_n      <= head[cur];
          cnt[cur]  <= cnt[cur] + 1'b1;
          head[cur] <= blk;
          state     <= (head[cur] < NIL) ? S_PU_H : S_AFTPU;
        end
        S_PU_H:  state <= S_PU_HW;
        S_PU_HW: state <= S_AFTPU;
        S_AFTPU: begin
          if (fn == FUNC_FREE) begin
            total <= total + (TW'(1) << req_ord);
            res   <= blk;
            state <= S_DONE;
          end else if (cur > req_ord) begin
            cur   <= cur - 1'b1;
            blk   <= bud + (LW'(1) << (cur - 1'b1));
            state <= S_PUSH;
          end else begin
            total <= total - (TW'(1) << req_ord);
            res   <= bud;
            state <= S_DONE;
          end
        end
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
